// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker in gpioei_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/gpioei_pkg.sv =====
`timescale 1ns / 1ps

package gpioei_pkg;

    localparam int PIN_COUNT_DEF  = 32;
    localparam int BANK_COUNT_DEF = 2;

    localparam int KIND_W = 2;
    localparam int REG_W  = 4;

    // Beat kinds
    localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    // Register map
    localparam logic [REG_W-1:0] REG_BANK_EN  = 4'd0;
    localparam logic [REG_W-1:0] REG_DIR      = 4'd1;
    localparam logic [REG_W-1:0] REG_SET_DATA = 4'd2;
    localparam logic [REG_W-1:0] REG_CLR_DATA = 4'd3;
    localparam logic [REG_W-1:0] REG_INPUT    = 4'd4;
    localparam logic [REG_W-1:0] REG_SET_RISE = 4'd5;
    localparam logic [REG_W-1:0] REG_CLR_RISE = 4'd6;
    localparam logic [REG_W-1:0] REG_SET_FALL = 4'd7;
    localparam logic [REG_W-1:0] REG_CLR_FALL = 4'd8;
    localparam logic [REG_W-1:0] REG_STATUS   = 4'd9;

endpackage

// ===== rtl/gpio_edge_interrupt_controller.sv =====
`timescale 1ns / 1ps
// An accepted beat is registered in the result or skid register. Throughput: one item
// per cycle while skid_reg is empty; a two-entry result buffer (result register plus
// skid register) keeps input accepted while one finished result waits downstream.
// Reset (rst_n, async, active low): every pin an input, latch, trigger enables,
// status, bank enables and last pin sample cleared; both result slots empty.

module gpio_edge_interrupt_controller #(
    parameter int PIN_COUNT  = gpioei_pkg::PIN_COUNT_DEF,
    parameter int BANK_COUNT = gpioei_pkg::BANK_COUNT_DEF,
    localparam int RD_W      = (PIN_COUNT > BANK_COUNT) ? PIN_COUNT : BANK_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item channel
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [gpioei_pkg::KIND_W-1:0] kind,
    input  logic [gpioei_pkg::REG_W-1:0]  reg_index,
    input  logic [RD_W-1:0]               write_data,
    input  logic [PIN_COUNT-1:0]          pins_in,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [RD_W-1:0]               read_data,
    output logic [PIN_COUNT-1:0]          pins_out,
    output logic [PIN_COUNT-1:0]          out_enable,
    output logic [BANK_COUNT-1:0]         bank_irq
);

    import gpioei_pkg::*;

    localparam int BANK_SIZE = PIN_COUNT / BANK_COUNT;

    typedef struct packed {
        logic [RD_W-1:0]       read_data;
        logic [PIN_COUNT-1:0]  pins_out;
        logic [PIN_COUNT-1:0]  out_enable;
        logic [BANK_COUNT-1:0] bank_irq;
    } result_t;

    // Architectural state
    logic [PIN_COUNT-1:0]  dir_reg,      dir_next;
    logic [PIN_COUNT-1:0]  latch_reg,    latch_next;
    logic [PIN_COUNT-1:0]  rise_en_reg,  rise_en_next;
    logic [PIN_COUNT-1:0]  fall_en_reg,  fall_en_next;
    logic [PIN_COUNT-1:0]  status_reg,   status_next;
    logic [BANK_COUNT-1:0] bank_en_reg,  bank_en_next;
    logic [PIN_COUNT-1:0]  sample_reg;

    // Result buffer: result_reg drives the ports, skid_reg catches a beat
    // that arrives while the result port is stalled.
    result_t result_reg;
    result_t skid_reg;
    logic    result_valid_reg;
    logic    skid_valid_reg;

    logic                  item_accept;
    logic                  result_take;
    logic [PIN_COUNT-1:0]  wd;
    logic [PIN_COUNT-1:0]  edges;
    logic [PIN_COUNT-1:0]  clr;
    logic [RD_W-1:0]       rd;
    logic [BANK_COUNT-1:0] irq;
    result_t               result_new;

    // Input is held off only while the skid slot is occupied.
    assign item_stall  = skid_valid_reg;
    assign item_accept = item_valid & ~item_stall;
    assign result_take = result_valid_reg & ~result_stall;

    assign wd = write_data[PIN_COUNT-1:0];

    // Edges use the trigger enables held before this beat's write.
    assign edges = (pins_in & ~sample_reg & rise_en_reg)
                 | (~pins_in & sample_reg & fall_en_reg);

    // Register access decode: read mux and next state.
    always_comb
    begin
        rd           = '0;
        clr          = '0;
        dir_next     = dir_reg;
        latch_next   = latch_reg;
        rise_en_next = rise_en_reg;
        fall_en_next = fall_en_reg;
        bank_en_next = bank_en_reg;

        unique case (kind)
            KIND_READ:
            begin
                unique case (reg_index) inside
                    REG_BANK_EN:                rd = RD_W'(bank_en_reg);
                    REG_DIR:                    rd = RD_W'(dir_reg);
                    REG_SET_DATA, REG_CLR_DATA: rd = RD_W'(latch_reg);
                    REG_INPUT:                  rd = RD_W'(pins_in);
                    REG_SET_RISE, REG_CLR_RISE: rd = RD_W'(rise_en_reg);
                    REG_SET_FALL, REG_CLR_FALL: rd = RD_W'(fall_en_reg);
                    REG_STATUS:                 rd = RD_W'(status_reg);
                    default:                    rd = '0;
                endcase
            end
            KIND_WRITE:
            begin
                unique case (reg_index)
                    REG_BANK_EN:  bank_en_next = write_data[BANK_COUNT-1:0];
                    REG_DIR:      dir_next     = wd;
                    REG_SET_DATA: latch_next   = latch_reg | wd;
                    REG_CLR_DATA: latch_next   = latch_reg & ~wd;
                    REG_SET_RISE: rise_en_next = rise_en_reg | wd;
                    REG_CLR_RISE: rise_en_next = rise_en_reg & ~wd;
                    REG_SET_FALL: fall_en_next = fall_en_reg | wd;
                    REG_CLR_FALL: fall_en_next = fall_en_reg & ~wd;
                    REG_STATUS:   clr          = wd;
                    default:      ;
                endcase
            end
            default: ;
        endcase
    end

    // A new edge beats a write-1-to-clear on the same beat.
    assign status_next = (status_reg & ~clr) | edges;

    // Bank requests: remainder pins beyond the last full bank belong to none.
    for (genvar k = 0; k < BANK_COUNT; k++)
    begin : g_bank
        localparam logic [PIN_COUNT-1:0] BANK_MASK =
            ({PIN_COUNT{1'b1}} >> (PIN_COUNT - BANK_SIZE)) << (k * BANK_SIZE);
        assign irq[k] = bank_en_next[k] & (|(status_next & BANK_MASK));
    end

    always_comb
    begin
        result_new.read_data  = rd;
        result_new.pins_out   = latch_next;
        result_new.out_enable = ~dir_next;
        result_new.bank_irq   = irq;
    end

    // State registers advance on every accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg     <= '1;
            latch_reg   <= '0;
            rise_en_reg <= '0;
            fall_en_reg <= '0;
            status_reg  <= '0;
            bank_en_reg <= '0;
            sample_reg  <= '0;
        end
        else if (item_accept)
        begin
            dir_reg     <= dir_next;
            latch_reg   <= latch_next;
            rise_en_reg <= rise_en_next;
            fall_en_reg <= fall_en_next;
            status_reg  <= status_next;
            bank_en_reg <= bank_en_next;
            sample_reg  <= pins_in;
        end
    end

    // Result buffer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (item_accept)
        begin
            // Skid is empty here; the new beat goes to whichever slot frees up.
            if (!result_valid_reg || result_take)
                result_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (result_take)
        begin
            result_valid_reg <= skid_valid_reg;
            skid_valid_reg   <= 1'b0;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            if (!result_valid_reg || result_take)
                result_reg <= result_new;
            else
                skid_reg <= result_new;
        end
        else if (result_take && skid_valid_reg)
        begin
            result_reg <= skid_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign read_data    = result_reg.read_data;
    assign pins_out     = result_reg.pins_out;
    assign out_enable   = result_reg.out_enable;
    assign bank_irq     = result_reg.bank_irq;

endmodule

// ===== rtl/gpioei_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gpioei_checker #(
    parameter int PIN_COUNT  = gpioei_pkg::PIN_COUNT_DEF,
    parameter int BANK_COUNT = gpioei_pkg::BANK_COUNT_DEF,
    localparam int RD_W      = (PIN_COUNT > BANK_COUNT) ? PIN_COUNT : BANK_COUNT
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_stall,
    input logic [gpioei_pkg::KIND_W-1:0] kind,
    input logic [gpioei_pkg::REG_W-1:0]  reg_index,
    input logic [RD_W-1:0]               write_data,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [RD_W-1:0]               read_data,
    input logic [PIN_COUNT-1:0]          pins_out,
    input logic [PIN_COUNT-1:0]          out_enable,
    input logic [BANK_COUNT-1:0]         bank_irq
);

    import gpioei_pkg::*;

    logic item_accept;
    logic lands_now;

    assign item_accept = item_valid & ~item_stall;
    // An accepted beat lands in the result register when that slot frees up.
    assign lands_now   = item_accept & (~result_valid | ~result_stall);

    `ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid)

    `ASSERT_NEXT(a_payload_hold, result_valid && result_stall,
                 $stable(read_data) && $stable(pins_out)
                 && $stable(out_enable) && $stable(bank_irq))

    `ASSERT_SAME(a_stall_needs_result, item_stall, result_valid)

    `ASSERT_NEXT(a_dir_to_oe, lands_now && kind == KIND_WRITE && reg_index == REG_DIR,
                 result_valid && out_enable == ~$past(write_data[PIN_COUNT-1:0]))

    `ASSERT_NEXT(a_nonread_zero, lands_now && kind != KIND_READ, result_valid && read_data == '0)

endmodule

bind gpio_edge_interrupt_controller gpioei_checker #(
    .PIN_COUNT(PIN_COUNT),
    .BANK_COUNT(BANK_COUNT)
) u_gpioei_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import gpioei_pkg::*;

    // Spare kind code: the block treats it as an idle tick.
    localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;
    // Highest encodable register index; everything above REG_STATUS is unmapped.
    localparam logic [REG_W-1:0]  REG_IDX_MAX = 4'hF;

    localparam int          HOLD_CYCLES   = 64;
    localparam int          DRAIN_CYCLES  = 4;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int          RANDOM_PHASE  = 250;
    localparam int          PRESSURE_BEATS = 100;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [REG_W-1:0]  reg_index;
        logic [31:0]       wdata;
        logic [31:0]       pins;
    } item_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic [31:0] latch;
        logic [31:0] oe;
        logic [1:0]  irq;
    } result_t;

    // Shadow copy of the controller: register state plus the queue of result beats
    // still owed by the block.
    class gpio_shadow;
        logic [31:0]   direction;
        logic [31:0]   out_latch;
        logic [31:0]   rise_en;
        logic [31:0]   fall_en;
        logic [31:0]   status;
        logic [31:0]   last_pins;
        logic [1:0]    bank_en;
        result_t       owed_q[$];
        int unsigned   fail_count;
        int unsigned   checked;
        int unsigned   reads;
        int unsigned   writes;
        int unsigned   edges_seen;
        int unsigned   irq_beats;

        function new();
            direction  = '1;
            out_latch  = '0;
            rise_en    = '0;
            fall_en    = '0;
            status     = '0;
            last_pins  = '0;
            bank_en    = '0;
            fail_count = 0;
            checked    = 0;
            reads      = 0;
            writes     = 0;
            edges_seen = 0;
            irq_beats  = 0;
        endfunction

        function void note_item(item_t it);
            logic [31:0] edges;
            logic [31:0] clr;
            result_t     res;
            edges = (it.pins & ~last_pins & rise_en) | (~it.pins & last_pins & fall_en);
            clr = '0;
            res.rdata = '0;
            if (it.kind == KIND_READ) begin
                reads++;
                case (it.reg_index) inside
                    REG_BANK_EN:               res.rdata = {30'b0, bank_en};
                    REG_DIR:                   res.rdata = direction;
                    REG_SET_DATA, REG_CLR_DATA: res.rdata = out_latch;
                    REG_INPUT:                 res.rdata = it.pins;
                    REG_SET_RISE, REG_CLR_RISE: res.rdata = rise_en;
                    REG_SET_FALL, REG_CLR_FALL: res.rdata = fall_en;
                    REG_STATUS:                res.rdata = status;
                    default:                   res.rdata = '0;
                endcase
            end else if (it.kind == KIND_WRITE) begin
                writes++;
                case (it.reg_index)
                    REG_BANK_EN:  bank_en   = it.wdata[1:0];
                    REG_DIR:      direction = it.wdata;
                    REG_SET_DATA: out_latch = out_latch | it.wdata;
                    REG_CLR_DATA: out_latch = out_latch & ~it.wdata;
                    REG_SET_RISE: rise_en   = rise_en | it.wdata;
                    REG_CLR_RISE: rise_en   = rise_en & ~it.wdata;
                    REG_SET_FALL: fall_en   = fall_en | it.wdata;
                    REG_CLR_FALL: fall_en   = fall_en & ~it.wdata;
                    REG_STATUS:   clr       = it.wdata;
                    default:      ;
                endcase
            end
            // A fresh edge beats a same-beat clear.
            status    = (status & ~clr) | edges;
            last_pins = it.pins;
            edges_seen += $countones(edges);
            res.latch  = out_latch;
            res.oe     = ~direction;
            res.irq[0] = bank_en[0] && (|status[15:0]);
            res.irq[1] = bank_en[1] && (|status[31:16]);
            if (res.irq != 2'b00)
                irq_beats++;
            owed_q.push_back(res);
        endfunction

        function void check_result(logic [31:0] rdata, logic [31:0] latch,
                                   logic [31:0] oe, logic [1:0] irq);
            result_t want;
            if (owed_q.size() == 0) begin
                $display("%0t: result beat with nothing owed: read_data %h pins_out %h",
                         $time, rdata, latch);
                fail_count++;
                return;
            end
            want = owed_q.pop_front();
            checked++;
            if (rdata !== want.rdata) begin
                $display("%0t: read_data mismatch: expected %h, got %h",
                         $time, want.rdata, rdata);
                fail_count++;
            end
            if (latch !== want.latch) begin
                $display("%0t: pins_out mismatch: expected %h, got %h",
                         $time, want.latch, latch);
                fail_count++;
            end
            if (oe !== want.oe) begin
                $display("%0t: out_enable mismatch: expected %h, got %h",
                         $time, want.oe, oe);
                fail_count++;
            end
            if (irq !== want.irq) begin
                $display("%0t: bank_irq mismatch: expected %b, got %b",
                         $time, want.irq, irq);
                fail_count++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    logic [KIND_W-1:0] kind;
    logic [REG_W-1:0]  reg_index;
    logic [31:0]       write_data;
    logic [31:0]       pins_in;
    logic              result_valid;
    logic              result_stall;
    logic [31:0]       read_data;
    logic [31:0]       pins_out;
    logic [31:0]       out_enable;
    logic [1:0]        bank_irq;

    gpio_shadow  shadow;
    int          sender_idle_pct;
    int          sink_stall_pct;
    logic        hold_active;
    logic        pressure_req;
    int unsigned input_stalls;
    int unsigned cycle_count;
    logic [31:0] pin_level;

    gpio_edge_interrupt_controller u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .pins_in      (pins_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .read_data    (read_data),
        .pins_out     (pins_out),
        .out_enable   (out_enable),
        .bank_irq     (bank_irq)
    );

    always #4 clk = ~clk;

    // Offer one item beat, with a random idle gap in front, and hold it until the
    // block takes it. The beat is noted in the shadow at the edge that accepts it.
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= it.kind;
        reg_index  <= it.reg_index;
        write_data <= it.wdata;
        pins_in    <= it.pins;
        @(posedge clk);
        while (item_stall)
        begin
            input_stalls++;
            @(posedge clk);
        end
        shadow.note_item(it);
    endtask

    task automatic send_fields(input logic [KIND_W-1:0] k, input logic [REG_W-1:0] r,
                               input logic [31:0] wd, input logic [31:0] p);
        item_t it;
        it = '{kind: k, reg_index: r, wdata: wd, pins: p};
        send_item(it);
    endtask

    // Build one random beat. Pins mostly wiggle a bit or two away from the last
    // level so edges stay sparse and status bits survive long enough to be read.
    task automatic send_random();
        item_t       it;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 30)
            it.kind = KIND_IDLE;
        else if (sel < 55)
            it.kind = KIND_READ;
        else if (sel < 95)
            it.kind = KIND_WRITE;
        else
            it.kind = KIND_SPARE;
        if ($urandom_range(99) < 92)
            it.reg_index = REG_W'($urandom_range(REG_STATUS, REG_BANK_EN));
        else
            it.reg_index = REG_W'($urandom_range(REG_IDX_MAX, REG_STATUS + 1));
        sel = $urandom_range(99);
        if (sel < 8)
            it.wdata = '0;
        else if (sel < 16)
            it.wdata = '1;
        else
            it.wdata = $urandom;
        sel = $urandom_range(99);
        if (sel < 55)
            pin_level = pin_level ^ (32'h1 << $urandom_range(31))
                                  ^ (32'h1 << $urandom_range(31));
        else if (sel < 85)
            pin_level = pin_level;
        else
            pin_level = $urandom;
        it.pins = pin_level;
        send_item(it);
    endtask

    // Result sink: check every accepted result beat, then pick the next stall.
    initial
    begin : result_sink
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                shadow.check_result(read_data, pins_out, out_enable, bank_irq);
            if (hold_active)
                result_stall <= 1'b1;
            else
                result_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Long hold-off on the result side, counted here while the sender keeps
    // offering beats, so the two result slots fill and the block stalls its input.
    initial
    begin : hold_off
        hold_active <= 1'b0;
        wait (pressure_req);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Watchdog: end the run if the block stops making progress.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d result beats still owed",
                 $time, cycle_count, shadow.pending());
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        shadow          = new();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        pressure_req    = 1'b0;
        input_stalls    = 0;
        pin_level       = '0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        kind       <= KIND_IDLE;
        reg_index  <= REG_BANK_EN;
        write_data <= '0;
        pins_in    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: reset values, every register, the field extremes.
        send_fields(KIND_IDLE,  REG_BANK_EN,  32'h0,         32'h0);
        send_fields(KIND_READ,  REG_DIR,      32'h0,         32'h0);
        send_fields(KIND_WRITE, REG_DIR,      32'h0,         32'h0);
        send_fields(KIND_WRITE, REG_SET_DATA, 32'hFFFF_FFFF, 32'h0);
        send_fields(KIND_WRITE, REG_CLR_DATA, 32'h0000_FFFF, 32'h0);
        send_fields(KIND_READ,  REG_CLR_DATA, 32'h0,         32'h0);
        send_fields(KIND_WRITE, REG_SET_RISE, 32'hFFFF_FFFF, 32'h0);
        send_fields(KIND_WRITE, REG_SET_FALL, 32'hFFFF_0000, 32'h0);
        // Bank enable keeps only its low two bits.
        send_fields(KIND_WRITE, REG_BANK_EN,  32'hFFFF_FFFF, 32'h0);
        send_fields(KIND_READ,  REG_BANK_EN,  32'h0,         32'h0);
        // Every pin rises: all status bits latch, both banks request.
        send_fields(KIND_IDLE,  REG_BANK_EN,  32'h0,         32'hFFFF_FFFF);
        send_fields(KIND_READ,  REG_STATUS,   32'h0,         32'hFFFF_FFFF);
        // Clear everything while the upper bank falls: those edges win the clear.
        send_fields(KIND_WRITE, REG_STATUS,   32'hFFFF_FFFF, 32'h0);
        send_fields(KIND_READ,  REG_INPUT,    32'h0,         32'hA5A5_5A5A);
        // Writes to input data and to unmapped indexes leave the state alone.
        send_fields(KIND_WRITE, REG_INPUT,    32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_fields(KIND_READ,  REG_IDX_MAX,  32'h0,         32'hA5A5_5A5A);
        send_fields(KIND_WRITE, REG_W'(REG_STATUS + 1), 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        // Spare kind acts as an idle tick.
        send_fields(KIND_SPARE, REG_IDX_MAX,  32'hFFFF_FFFF, 32'h0);
        send_fields(KIND_WRITE, REG_CLR_RISE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(KIND_WRITE, REG_CLR_FALL, 32'h00FF_00FF, 32'h0);
        send_fields(KIND_READ,  REG_SET_RISE, 32'h0,         32'h0);
        send_fields(KIND_READ,  REG_SET_FALL, 32'h0,         32'h0);
        send_fields(KIND_WRITE, REG_STATUS,   32'hFFFF_FFFF, 32'h0);
        send_fields(KIND_WRITE, REG_DIR,      32'hFFFF_FFFF, 32'h0);
        send_fields(KIND_WRITE, REG_BANK_EN,  32'h0,         32'h0);

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin sender_idle_pct = 62; sink_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  sink_stall_pct = 62; end
                default: begin sender_idle_pct = 18; sink_stall_pct = 18; end
            endcase
            repeat (RANDOM_PHASE) send_random();
        end

        // Back-pressure: push beats flat out while the sink holds off.
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        pressure_req    = 1'b1;
        repeat (PRESSURE_BEATS) send_random();

        // Drop valid, wait for every owed beat, then let the pipeline settle.
        item_valid <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d result beats: %0d reads, %0d writes, %0d input stall cycles",
                 shadow.checked, shadow.reads, shadow.writes, input_stalls);
        $display("latched %0d pin edges, %0d beats with a bank interrupt raised",
                 shadow.edges_seen, shadow.irq_beats);
        if (shadow.fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
